/* rtl/jsu_pkg.sv */
// shared types, codes and helper functions for the json string unescaper
// no dependencies
package jsu_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_DATA    = 3'd0;
    localparam t_status ST_CLOSED  = 3'd1;
    localparam t_status ST_NOQUOTE = 3'd2;
    localparam t_status ST_BADHEX  = 3'd3;
    localparam t_status ST_SHORT   = 3'd4;
    localparam t_status ST_UNTERM  = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U = 8'h75;

    typedef enum logic [3:0] {
        PH_WAIT = 4'b0001,
        PH_STR  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  digit_count;
        logic [15:0] code_point;
        logic        bad_digit_seen;
    } t_state;

    typedef struct packed {
        logic [1:0] cnt;
        t_status    status;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_res;

    // value of a hex digit, bit 4 set when the byte is not one
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            v = {1'b0, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic logic [7:0] simple_escape(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            8'h62: r = 8'h08;
            8'h66: r = 8'h0C;
            8'h6E: r = 8'h0A;
            8'h72: r = 8'h0D;
            8'h74: r = 8'h09;
            default: r = e;
        endcase
        return r;
    endfunction

endpackage

/* rtl/jsu_decode.sv */
// next-state and result logic for one text byte of the string unescaper
// depends on jsu_pkg
module jsu_decode import jsu_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_state     o_state,
    output t_res       o_res
);

    logic [4:0]  hv;
    logic [15:0] cp_next;
    logic        bad_next;

    assign hv       = hex_value(i_byte);
    assign cp_next  = {i_state.code_point[11:0], hv[4] ? 4'h0 : hv[3:0]};
    assign bad_next = i_state.bad_digit_seen | hv[4];

    always_comb begin
        o_state      = i_state;
        o_res.cnt    = 2'd0;
        o_res.status = ST_DATA;
        o_res.b0     = 8'h00;
        o_res.b1     = 8'h00;
        o_res.b2     = 8'h00;
        case (i_state.phase)
            PH_WAIT: begin
                if (!i_end) begin
                    if (i_byte == CH_QUOTE) begin
                        o_state.phase = PH_STR;
                    end else begin
                        o_res.cnt    = 2'd1;
                        o_res.status = ST_NOQUOTE;
                    end
                end
            end
            PH_STR: begin
                if (i_end) begin
                    o_res.cnt     = 2'd1;
                    o_res.status  = ST_UNTERM;
                    o_state.phase = PH_WAIT;
                end else if (i_byte == CH_QUOTE) begin
                    o_res.cnt     = 2'd1;
                    o_res.status  = ST_CLOSED;
                    o_state.phase = PH_WAIT;
                end else if (i_byte == CH_BSLASH) begin
                    o_state.phase = PH_ESC;
                end else begin
                    o_res.cnt = 2'd1;
                    o_res.b0  = i_byte;
                end
            end
            PH_ESC: begin
                if (i_end) begin
                    o_res.cnt     = 2'd1;
                    o_res.status  = ST_UNTERM;
                    o_state.phase = PH_WAIT;
                end else if (i_byte == CH_U) begin
                    o_state.phase          = PH_HEX;
                    o_state.digit_count    = 2'd0;
                    o_state.code_point     = 16'h0000;
                    o_state.bad_digit_seen = 1'b0;
                end else begin
                    o_res.cnt     = 2'd1;
                    o_res.b0      = simple_escape(i_byte);
                    o_state.phase = PH_STR;
                end
            end
            PH_HEX: begin
                if (i_end) begin
                    o_res.cnt     = 2'd1;
                    o_res.status  = ST_SHORT;
                    o_state.phase = PH_WAIT;
                end else begin
                    o_state.code_point     = cp_next;
                    o_state.bad_digit_seen = bad_next;
                    if (i_state.digit_count != 2'd3) begin
                        o_state.digit_count = i_state.digit_count + 2'd1;
                    end else begin
                        o_state.digit_count = 2'd0;
                        if (bad_next) begin
                            o_res.cnt     = 2'd1;
                            o_res.status  = ST_BADHEX;
                            o_state.phase = PH_WAIT;
                        end else begin
                            o_state.phase = PH_STR;
                            if (cp_next[15:7] == 9'd0) begin
                                o_res.cnt = 2'd1;
                                o_res.b0  = {1'b0, cp_next[6:0]};
                            end else if (cp_next[15:11] == 5'd0) begin
                                o_res.cnt = 2'd2;
                                o_res.b0  = {3'b110, cp_next[10:6]};
                                o_res.b1  = {2'b10, cp_next[5:0]};
                            end else begin
                                o_res.cnt = 2'd3;
                                o_res.b0  = {4'b1110, cp_next[15:12]};
                                o_res.b1  = {2'b10, cp_next[11:6]};
                                o_res.b2  = {2'b10, cp_next[5:0]};
                            end
                        end
                    end
                end
            end
            default: begin
                o_state.phase = PH_WAIT;
            end
        endcase
    end

endmodule

/* rtl/json_string_unescape.sv */
// top level of the streaming json string unescaper: input register, decode, result buffer
// depends on jsu_pkg and jsu_decode
// an accepted byte is decoded from the input register into the result buffer once it frees
// throughput: one byte per cycle while the receiver is ready; a closing \u escape holds
// the input for its 2 or 3 results; the result buffer of up to three bytes sets the rate
// reset: synchronous, active low; clears the decoder state and both valid flags
module json_string_unescape import jsu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tuser,   // [0] at_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [10:8] status, rest zero
    output logic        o_m_tlast
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    t_state     r_state;
    t_state     n_state;
    t_res       n_res;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    t_status    r_status;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic [7:0] r_b2;
    logic [7:0] out_byte;
    logic       is_last;
    logic       out_take;
    logic       out_done;
    logic       in_use;

    jsu_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_state (n_state),
        .o_res   (n_res)
    );

    assign is_last    = (r_idx == r_cnt - 2'd1);
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign out_take   = o_m_tvalid && i_m_tready;
    assign out_done   = out_take && is_last;
    assign in_use     = r_in_valid && (!o_m_tvalid || out_done);
    assign o_s_tready = !r_in_valid || in_use;

    always_comb begin
        case (r_idx)
            2'd1: out_byte = r_b1;
            2'd2: out_byte = r_b2;
            default: out_byte = r_b0;
        endcase
    end

    assign o_m_tdata = {5'b00000, r_status, out_byte};
    assign o_m_tlast = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (in_use) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_end  <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_WAIT;
            r_state.digit_count    <= 2'd0;
            r_state.code_point     <= 16'h0000;
            r_state.bad_digit_seen <= 1'b0;
            r_cnt                  <= 2'd0;
            r_idx                  <= 2'd0;
        end else if (in_use) begin
            r_state <= n_state;
            r_cnt   <= n_res.cnt;
            r_idx   <= 2'd0;
        end else if (out_done) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (out_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_use) begin
            r_status <= n_res.status;
            r_b0     <= n_res.b0;
            r_b1     <= n_res.b1;
            r_b2     <= n_res.b2;
        end
    end

endmodule

/* rtl/jsu_chk.sv */
// port-level checker for the json string unescaper, bound to the top level
// depends on json_string_unescape
module jsu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[10:8] <= 3'd5 && o_m_tdata[15:11] == 5'd0)
        else $error("status out of range");

    a_flag_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[10:8] != 3'd0 |-> o_m_tdata[7:0] == 8'h00 && o_m_tlast)
        else $error("status result not alone or carries a byte");

    a_multi_utf8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[10:8] == 3'd0 && o_m_tdata[7])
        else $error("multi-byte transaction is not a utf-8 sequence");

endmodule

bind json_string_unescape jsu_chk u_jsu_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

/* sim/json_string_unescape_test.sv */
// self-checking testbench for json_string_unescape: directed table then random strings, mostly quoted
// expected results come from the table for typed rows, otherwise from a behavioural decoder kept inside this file
// depends on jsu_pkg and the json_string_unescape rtl
module json_string_unescape_test import jsu_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD = 10;
    localparam int LIMIT = 100000;
    localparam int HOLD_LEN = 64;
    localparam int PHASE_ITEMS = 80;
    localparam logic [63:0] ESC_SET = "\"\\/bfnrt";
    localparam logic [127:0] CP_EDGE = {16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                        16'h0800, 16'hFFFF, 16'hD800, 16'hDFFF};

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_exp;

    typedef struct {
        logic [7:0] b;
        logic       e;
        bit         typed;
        int         n;
        t_status    st;
        logic [7:0] ob;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;

    t_exp   decoded_q[$];
    t_exp   step_res[3];
    int     step_n;
    t_row   tab[$];
    t_exp   want;
    int     errors = 0;
    int     cycles = 0;
    int     text_items = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_asked = 0;
    int     hold_seen = 0;
    int     hold_left = 0;

    t_phase      dec_phase = PH_WAIT;
    logic [1:0]  dec_digits = 2'd0;
    logic [15:0] dec_cp = 16'h0000;
    logic        dec_bad = 1'b0;

    json_string_unescape i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] in_byte
        .i_s_tuser  (i_s_tuser),   // [0] at_end
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [7:0] out_byte, [10:8] status
        .o_m_tlast  (o_m_tlast)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls plus a single long hold-off in the last random phase
    always @(negedge i_clk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, got data %h last %b",
                         $time, o_m_tdata, o_m_tlast);
            end else begin
                want = decoded_q.pop_front();
                if (o_m_tdata[7:0] !== want.data) begin
                    errors++;
                    $display("%0t: out_byte expected %h, actual %h",
                             $time, want.data, o_m_tdata[7:0]);
                end
                if (o_m_tdata[10:8] !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, o_m_tdata[10:8]);
                end
                if (o_m_tdata[15:11] !== 5'd0) begin
                    errors++;
                    $display("%0t: padding expected 0, actual %h", $time, o_m_tdata[15:11]);
                end
                if (o_m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b, actual %b", $time, want.last, o_m_tlast);
                end
            end
        end
    end

    function automatic void emit(input logic [7:0] d, input t_status s);
        step_res[step_n] = '{data: d, status: s, last: 1'b0};
        step_n++;
    endfunction

    task automatic decode_step(input logic [7:0] b, input logic e);
        logic [7:0] t;
        logic [3:0] nib;
        logic       ok;
        step_n = 0;
        case (dec_phase)
            PH_WAIT: begin
                if (!e) begin
                    if (b == CH_QUOTE) dec_phase = PH_STR;
                    else emit(8'h00, ST_NOQUOTE);
                end
            end
            PH_STR: begin
                if (e) begin
                    emit(8'h00, ST_UNTERM);
                    dec_phase = PH_WAIT;
                end else if (b == CH_QUOTE) begin
                    emit(8'h00, ST_CLOSED);
                    dec_phase = PH_WAIT;
                end else if (b == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                end else begin
                    emit(b, ST_DATA);
                end
            end
            PH_ESC: begin
                if (e) begin
                    emit(8'h00, ST_UNTERM);
                    dec_phase = PH_WAIT;
                end else if (b == CH_U) begin
                    dec_phase = PH_HEX;
                    dec_digits = 2'd0;
                    dec_cp = 16'h0000;
                    dec_bad = 1'b0;
                end else begin
                    case (b)
                        "b": emit(8'h08, ST_DATA);
                        "f": emit(8'h0C, ST_DATA);
                        "n": emit(8'h0A, ST_DATA);
                        "r": emit(8'h0D, ST_DATA);
                        "t": emit(8'h09, ST_DATA);
                        default: emit(b, ST_DATA);
                    endcase
                    dec_phase = PH_STR;
                end
            end
            default: begin
                if (e) begin
                    emit(8'h00, ST_SHORT);
                    dec_phase = PH_WAIT;
                end else begin
                    ok = 1'b1;
                    t = 8'h00;
                    if (b >= "0" && b <= "9") t = b - 8'h30;
                    else if (b >= "a" && b <= "f") t = b - 8'h57;
                    else if (b >= "A" && b <= "F") t = b - 8'h37;
                    else ok = 1'b0;
                    nib = t[3:0];
                    if (!ok) dec_bad = 1'b1;
                    dec_cp = {dec_cp[11:0], nib};
                    if (dec_digits != 2'd3) begin
                        dec_digits = dec_digits + 2'd1;
                    end else begin
                        dec_digits = 2'd0;
                        if (dec_bad) begin
                            emit(8'h00, ST_BADHEX);
                            dec_phase = PH_WAIT;
                        end else begin
                            if (dec_cp < 16'h0080) begin
                                emit(dec_cp[7:0], ST_DATA);
                            end else if (dec_cp < 16'h0800) begin
                                emit({3'b110, dec_cp[10:6]}, ST_DATA);
                                emit({2'b10, dec_cp[5:0]}, ST_DATA);
                            end else begin
                                emit({4'b1110, dec_cp[15:12]}, ST_DATA);
                                emit({2'b10, dec_cp[11:6]}, ST_DATA);
                                emit({2'b10, dec_cp[5:0]}, ST_DATA);
                            end
                            dec_phase = PH_STR;
                        end
                    end
                end
            end
        endcase
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
    endtask

    // returns at the rising edge where the transaction is taken
    task automatic offer(input logic [7:0] b, input logic e);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tuser <= e;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic feed(input logic [7:0] b, input logic e);
        int k;
        if (!(e && dec_phase == PH_WAIT)) text_items++;
        offer(b, e);
        decode_step(b, e);
        for (k = 0; k < step_n; k++) decoded_q = {decoded_q, step_res[k]};
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // backslash-u with ndig digits, a non-hex byte at bad_pos
    task automatic hex_escape(input int ndig, input int bad_pos);
        logic [15:0] cp;
        logic [7:0]  b;
        int          idx;
        int          i;
        idx = $urandom_range(7);
        case ($urandom_range(3))
            0: cp = 16'($urandom_range(16'h007F));
            1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
            2: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
            default: cp = CP_EDGE[16 * idx +: 16];
        endcase
        feed(CH_BSLASH, 1'b0);
        feed(CH_U, 1'b0);
        for (i = 0; i < ndig; i++) begin
            if (i == bad_pos) begin
                do b = 8'($urandom_range(255));
                while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
            end else begin
                b = hex_char(cp[15 - 4 * i -: 4]);
            end
            feed(b, 1'b0);
        end
    endtask

    task automatic random_string();
        logic [7:0] b;
        int         body;
        int         kind;
        int         r;
        int         k;
        if ($urandom_range(99) < 8) begin
            b = 8'($urandom_range(255));
            if (b == CH_QUOTE) b = 8'h27;
            feed(b, 1'b0);
            return;
        end
        feed(CH_QUOTE, 1'b0);
        body = $urandom_range(6);
        for (k = 0; k < body; k++) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                b = 8'($urandom_range(255));
                if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
                feed(b, 1'b0);
            end else if (kind < 6) begin
                r = $urandom_range(7);
                feed(CH_BSLASH, 1'b0);
                feed(ESC_SET[8 * r +: 8], 1'b0);
            end else if (kind < 7) begin
                b = 8'($urandom_range(255));
                if (b == CH_U) b = 8'h76;
                feed(CH_BSLASH, 1'b0);
                feed(b, 1'b0);
            end else begin
                hex_escape(4, -1);
            end
        end
        r = $urandom_range(99);
        if (r < 72) begin
            feed(CH_QUOTE, 1'b0);
        end else if (r < 78) begin
            feed(8'($urandom_range(255)), 1'b1);
        end else if (r < 83) begin
            feed(CH_BSLASH, 1'b0);
            feed(8'($urandom_range(255)), 1'b1);
        end else if (r < 91) begin
            hex_escape($urandom_range(3), $urandom_range(4));
            feed(8'($urandom_range(255)), 1'b1);
        end else begin
            hex_escape(4, $urandom_range(3));
        end
        if ($urandom_range(99) < 15) feed(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic void put_row(input logic [7:0] b, input logic e, input bit typed,
                                    input int n, input t_status st, input logic [7:0] ob);
        t_row r;
        r.b = b;
        r.e = e;
        r.typed = typed;
        r.n = n;
        r.st = st;
        r.ob = ob;
        tab = {tab, r};
    endfunction

    initial begin
        t_exp r;
        int   ph;
        int   k;

        put_row(8'hA5, 1'b1, 1, 0, ST_DATA, 8'h00);
        put_row(8'hFF, 1'b0, 1, 1, ST_NOQUOTE, 8'h00);
        put_row(8'h00, 1'b0, 1, 1, ST_NOQUOTE, 8'h00);
        put_row(CH_QUOTE, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row(8'h00, 1'b0, 1, 1, ST_DATA, 8'h00);
        put_row(8'hFF, 1'b0, 1, 1, ST_DATA, 8'hFF);
        put_row(CH_BSLASH, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row("t", 1'b0, 1, 1, ST_DATA, 8'h09);
        put_row(CH_BSLASH, 1'b0, 0, 0, ST_DATA, 8'h00);
        put_row(CH_U, 1'b0, 0, 0, ST_DATA, 8'h00);
        put_row("F", 1'b0, 0, 0, ST_DATA, 8'h00);
        put_row("f", 1'b0, 0, 0, ST_DATA, 8'h00);
        put_row("f", 1'b0, 0, 0, ST_DATA, 8'h00);
        put_row("F", 1'b0, 0, 0, ST_DATA, 8'h00);
        put_row(CH_QUOTE, 1'b0, 1, 1, ST_CLOSED, 8'h00);
        put_row(CH_QUOTE, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row(CH_BSLASH, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row(8'hFF, 1'b1, 1, 1, ST_UNTERM, 8'h00);
        put_row(CH_QUOTE, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row(CH_BSLASH, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row(CH_U, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row("g", 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row("1", 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row("2", 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row("3", 1'b0, 1, 1, ST_BADHEX, 8'h00);
        put_row(CH_QUOTE, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row(CH_BSLASH, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row(CH_U, 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row("X", 1'b0, 1, 0, ST_DATA, 8'h00);
        put_row(8'h00, 1'b1, 1, 1, ST_SHORT, 8'h00);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 47;
        foreach (tab[i]) begin
            offer(tab[i].b, tab[i].e);
            decode_step(tab[i].b, tab[i].e);
            if (tab[i].typed) begin
                if (tab[i].n != 0) begin
                    r = '{data: tab[i].ob, status: tab[i].st, last: 1'b1};
                    decoded_q = {decoded_q, r};
                end
            end else begin
                for (k = 0; k < step_n; k++) decoded_q = {decoded_q, step_res[k]};
            end
        end
        drain();

        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 47 : 0;
            recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 28 : 0;
            if (ph == 2) hold_asked++;
            text_items = 0;
            while (text_items < PHASE_ITEMS) random_string();
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0 && decoded_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* json_string_unescape.f */
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/json_string_unescape.sv
rtl/jsu_chk.sv
sim/json_string_unescape_test.sv
